// ===== hw/rtl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// types and constants shared by the dirty rectangle coalescer
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int COORD_BITS        = 16;
  localparam int CLIENT_BITS       = 4;
  localparam int CLIENT_SLOTS      = 16;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int TOL_BITS          = 16;

  localparam logic [TOL_BITS-1:0] TEXT_TOL_RESET    = 16'd10;
  localparam logic [TOL_BITS-1:0] GRAPHIC_TOL_RESET = 16'd40;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // configuration register indexes
  localparam logic CFG_TEXT_TOL    = 1'b0;
  localparam logic CFG_GRAPHIC_TOL = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [CLIENT_BITS-1:0]        client;
    logic                          client_is_graphic;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic [COORD_BITS-1:0]         size_w;
    logic [COORD_BITS-1:0]         size_h;
  } drc_in_t;

  typedef struct packed {
    logic [CLIENT_BITS-1:0]        out_client;
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_y;
    logic [COORD_BITS-1:0]         out_w;
    logic [COORD_BITS-1:0]         out_h;
    logic                          final_of_run;
  } drc_out_t;

  typedef struct packed {
    logic [CLIENT_BITS-1:0]        owner;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
    logic [COORD_BITS-1:0]         w;
    logic [COORD_BITS-1:0]         h;
  } drc_entry_t;

endpackage

// ===== hw/rtl/dirty_rect_coalescer.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_coalescer
// table of pending screen update rectangles, merging nearby updates
// ----------------------------------------------------------------------------
//  channel  | signals                                | transaction
//  ---------+----------------------------------------+----------------------------
//  in       | in_valid_i, in_stall_o, in_data_i      | add rectangle or flush
//  out      | out_valid_o, out_stall_i, out_data_o   | one emitted rectangle
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i        | tolerance register write
//
//  an add scans the table through the entry memory, one entry a cycle, then
//  merges into the matching entry (MERGE, WBACK) or appends (APPEND).
//  each emitted rectangle passes a memory read and an output register load.
//  a flush of a non-empty table, or an unmatched add to a full one, emits the whole table.
//  reset clears the entry count and loads the default tolerances.
//  in_stall_o is high while an item is at work; out_stall_i holds the run.
// ----------------------------------------------------------------------------
module dirty_rect_coalescer
  import drc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  drc_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drc_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [TOL_BITS-1:0] cfg_data_i
);

  localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam int CW   = COORD_BITS;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_MERGE   = 3'd2;
  localparam logic [2:0] ST_WBACK   = 3'd3;
  localparam logic [2:0] ST_APPEND  = 3'd4;
  localparam logic [2:0] ST_EMIT_RD = 3'd5;
  localparam logic [2:0] ST_EMIT_WR = 3'd6;

  drc_entry_t entry_mem [TABLE_ENTRIES];

  logic [2:0]          state_q, state_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                append_after_q, append_after_d;
  logic [TOL_BITS-1:0] text_tol_q, graphic_tol_q;
  drc_in_t             item_q;
  logic [TOL_BITS-1:0] tol_q;
  drc_entry_t          rdata_q;
  logic                out_valid_q;
  drc_out_t            out_data_q;

  logic signed [CW-1:0] l_q, t_q;
  logic signed [CW+1:0] r_q, b_q;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  drc_entry_t      wr_data;
  logic            accept;
  logic            out_free;
  logic            out_load;
  logic            idx_last;
  logic            match;

  logic [CW:0] dx, dy, dw, dh;
  logic        x_ok, y_ok, w_ok, h_ok;

  logic signed [CW+1:0] r1, r2, b1, b2;
  logic signed [CW-1:0] l_d, t_d;
  logic signed [CW+1:0] r_d, b_d;
  logic signed [CW+1:0] span_w, span_h;
  logic [CW-1:0]        new_w, new_h;

  function automatic logic [CW:0] mag(input logic [CW:0] d);
    mag = d[CW] ? (~d + 1'b1) : d;
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_last = ((CNTW'(idx_q) + CNTW'(1)) == count_q);

  // scan compare against the entry read last cycle
  always_comb begin
    dx = mag({rdata_q.x[CW-1], rdata_q.x} - {item_q.pos_x[CW-1], item_q.pos_x});
    dy = mag({rdata_q.y[CW-1], rdata_q.y} - {item_q.pos_y[CW-1], item_q.pos_y});
    dw = mag({1'b0, rdata_q.w} - {1'b0, item_q.size_w});
    dh = mag({1'b0, rdata_q.h} - {1'b0, item_q.size_h});
    x_ok = dx < {1'b0, tol_q};
    y_ok = dy < {1'b0, tol_q};
    w_ok = dw < {1'b0, tol_q};
    h_ok = dh < {1'b0, tol_q};
    match = (rdata_q.owner == item_q.client) && x_ok && y_ok && w_ok && h_ok;
  end

  // bounding box edges
  always_comb begin
    r1  = $signed({{2{rdata_q.x[CW-1]}}, rdata_q.x}) + $signed({2'b00, rdata_q.w});
    r2  = $signed({{2{item_q.pos_x[CW-1]}}, item_q.pos_x}) + $signed({2'b00, item_q.size_w});
    b1  = $signed({{2{rdata_q.y[CW-1]}}, rdata_q.y}) + $signed({2'b00, rdata_q.h});
    b2  = $signed({{2{item_q.pos_y[CW-1]}}, item_q.pos_y}) + $signed({2'b00, item_q.size_h});
    l_d = (rdata_q.x < item_q.pos_x) ? rdata_q.x : item_q.pos_x;
    t_d = (rdata_q.y < item_q.pos_y) ? rdata_q.y : item_q.pos_y;
    r_d = (r1 > r2) ? r1 : r2;
    b_d = (b1 > b2) ? b1 : b2;
  end

  // saturated sizes
  always_comb begin
    span_w = r_q - $signed({{2{l_q[CW-1]}}, l_q});
    span_h = b_q - $signed({{2{t_q[CW-1]}}, t_q});
    new_w  = (span_w[CW+1:CW] != 2'b00) ? '1 : span_w[CW-1:0];
    new_h  = (span_h[CW+1:CW] != 2'b00) ? '1 : span_h[CW-1:0];
  end

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    idx_d          = idx_q;
    append_after_d = append_after_q;
    rd_en          = 1'b0;
    rd_addr        = idx_q;
    wr_en          = 1'b0;
    wr_addr        = idx_q;
    wr_data        = rdata_q;
    out_load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (in_data_i.command == CMD_FLUSH) begin
            if (count_q != '0) begin
              append_after_d = 1'b0;
              state_d        = ST_EMIT_RD;
            end
          end else if (int'(in_data_i.client) < CLIENT_SLOTS) begin
            if (count_q == '0) begin
              state_d = ST_APPEND;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = ST_MERGE;
        end else if (idx_last) begin
          idx_d = '0;
          if (count_q == CNTW'(TABLE_ENTRIES)) begin
            append_after_d = 1'b1;
            state_d        = ST_EMIT_RD;
          end else begin
            state_d = ST_APPEND;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end
      ST_MERGE: begin
        state_d = ST_WBACK;
      end
      ST_WBACK: begin
        wr_en         = 1'b1;
        wr_addr       = idx_q;
        wr_data.owner = rdata_q.owner;
        wr_data.x     = l_q;
        wr_data.y     = t_q;
        wr_data.w     = new_w;
        wr_data.h     = new_h;
        state_d       = ST_IDLE;
      end
      ST_APPEND: begin
        wr_en         = 1'b1;
        wr_addr       = count_q[IW-1:0];
        wr_data.owner = item_q.client;
        wr_data.x     = item_q.pos_x;
        wr_data.y     = item_q.pos_y;
        wr_data.w     = item_q.size_w;
        wr_data.h     = item_q.size_h;
        count_d       = count_q + 1'b1;
        state_d       = ST_IDLE;
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx_last) begin
            count_d = '0;
            state_d = append_after_q ? ST_APPEND : ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      idx_q          <= '0;
      append_after_q <= 1'b0;
      text_tol_q     <= TEXT_TOL_RESET;
      graphic_tol_q  <= GRAPHIC_TOL_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      idx_q          <= idx_d;
      append_after_q <= append_after_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEXT_TOL:    text_tol_q    <= cfg_data_i;
          CFG_GRAPHIC_TOL: graphic_tol_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      tol_q  <= in_data_i.client_is_graphic ? graphic_tol_q : text_tol_q;
    end
    if (state_q == ST_MERGE) begin
      l_q <= l_d;
      t_q <= t_d;
      r_q <= r_d;
      b_q <= b_d;
    end
    if (out_load) begin
      out_data_q.out_client   <= rdata_q.owner;
      out_data_q.out_x        <= rdata_q.x;
      out_data_q.out_y        <= rdata_q.y;
      out_data_q.out_w        <= rdata_q.w;
      out_data_q.out_h        <= rdata_q.h;
      out_data_q.final_of_run <= idx_last;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= entry_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/sv/tb_dirty_rect_coalescer.sv =====
// ----------------------------------------------------------------------------
// tb_dirty_rect_coalescer
// self-checking testbench for the dirty rectangle coalescer: a table model
// predicts merges, appends and emitted runs; directed cases cover tolerance
// edges, saturation and table overflow under a long output hold, then
// random update streams follow at several tolerance settings, with and
// without random idling
module tb_dirty_rect_coalescer;
  import drc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  drc_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  drc_out_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_idx_i   = CFG_TEXT_TOL;
  logic [TOL_BITS-1:0] cfg_data_i  = '0;

  drc_entry_t          rect_table [TABLE_ENTRIES_DEF];
  int                  rect_count  = 0;
  logic [TOL_BITS-1:0] text_tol    = TEXT_TOL_RESET;
  logic [TOL_BITS-1:0] graphic_tol = GRAPHIC_TOL_RESET;
  drc_out_t            expected_rects [$];

  int                  fail_count   = 0;
  int                  quiet_cycles = 0;
  int                  hold_left    = 0;
  bit                  idle_on      = 1'b1;
  int                  base_x [CLIENT_SLOTS];
  int                  base_y [CLIENT_SLOTS];
  int                  base_w [CLIENT_SLOTS];
  int                  base_h [CLIENT_SLOTS];

  dirty_rect_coalescer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint abs_diff(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void emit_table();
    drc_out_t r;
    for (int i = 0; i < rect_count; i++) begin
      r.out_client   = rect_table[i].owner;
      r.out_x        = rect_table[i].x;
      r.out_y        = rect_table[i].y;
      r.out_w        = rect_table[i].w;
      r.out_h        = rect_table[i].h;
      r.final_of_run = (i == rect_count - 1);
      expected_rects.push_back(r);
    end
    rect_count = 0;
  endfunction

  function automatic void coalesce_update(drc_in_t item);
    longint nx, ny, nw, nh, ex, ey, ew, eh, tol, l, t, r, b;
    if (item.command == CMD_FLUSH) begin
      emit_table();
      return;
    end
    tol = item.client_is_graphic ? longint'(graphic_tol) : longint'(text_tol);
    nx  = longint'($signed(item.pos_x));
    ny  = longint'($signed(item.pos_y));
    nw  = longint'(item.size_w);
    nh  = longint'(item.size_h);
    for (int i = 0; i < rect_count; i++) begin
      ex = longint'($signed(rect_table[i].x));
      ey = longint'($signed(rect_table[i].y));
      ew = longint'(rect_table[i].w);
      eh = longint'(rect_table[i].h);
      if (rect_table[i].owner == item.client && abs_diff(ex, nx) < tol &&
          abs_diff(ey, ny) < tol && abs_diff(ew, nw) < tol && abs_diff(eh, nh) < tol) begin
        l = (ex < nx) ? ex : nx;
        t = (ey < ny) ? ey : ny;
        r = (ex + ew > nx + nw) ? ex + ew : nx + nw;
        b = (ey + eh > ny + nh) ? ey + eh : ny + nh;
        rect_table[i].x = COORD_BITS'(l);
        rect_table[i].y = COORD_BITS'(t);
        rect_table[i].w = (r - l > 65535) ? 16'hFFFF : COORD_BITS'(r - l);
        rect_table[i].h = (b - t > 65535) ? 16'hFFFF : COORD_BITS'(b - t);
        return;
      end
    end
    if (rect_count == TABLE_ENTRIES_DEF) emit_table();
    rect_table[rect_count].owner = item.client;
    rect_table[rect_count].x     = item.pos_x;
    rect_table[rect_count].y     = item.pos_y;
    rect_table[rect_count].w     = item.size_w;
    rect_table[rect_count].h     = item.size_h;
    rect_count++;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_rect(drc_out_t got);
    drc_out_t want;
    if (expected_rects.size() == 0) begin
      $error("rectangle with none expected: client %0d x %0d y %0d",
             got.out_client, $signed(got.out_x), $signed(got.out_y));
      fail_count++;
      return;
    end
    want = expected_rects.pop_front();
    check_field("out_client", want.out_client, got.out_client);
    check_field("out_x", $signed(want.out_x), $signed(got.out_x));
    check_field("out_y", $signed(want.out_y), $signed(got.out_y));
    check_field("out_w", want.out_w, got.out_w);
    check_field("out_h", want.out_h, got.out_h);
    check_field("final_of_run", want.final_of_run, got.final_of_run);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) check_rect(out_data_o);
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 36);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dirty_rect_coalescer regression: fail");
      $finish;
    end
  end

  task automatic send_item(drc_in_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    coalesce_update(item);
    if (idle_on && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerances(logic [TOL_BITS-1:0] text_val,
                                  logic [TOL_BITS-1:0] graphic_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TEXT_TOL;
    cfg_data_i <= text_val;
    @(posedge clk_i);
    text_tol = text_val;
    cfg_idx_i  <= CFG_GRAPHIC_TOL;
    cfg_data_i <= graphic_val;
    @(posedge clk_i);
    graphic_tol = graphic_val;
    cfg_we_i <= 1'b0;
  endtask

  function automatic drc_in_t rect_item(logic cmd, int client, bit graphic,
                                        int x, int y, int w, int h);
    drc_in_t item;
    item.command           = cmd;
    item.client            = CLIENT_BITS'(client);
    item.client_is_graphic = graphic;
    item.pos_x             = COORD_BITS'(x);
    item.pos_y             = COORD_BITS'(y);
    item.size_w            = COORD_BITS'(w);
    item.size_h            = COORD_BITS'(h);
    return item;
  endfunction

  function automatic drc_in_t random_rect();
    return rect_item(CMD_ADD, $urandom_range(15), 1'($urandom_range(1)),
                     $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(65535));
  endfunction

  function automatic logic [COORD_BITS-1:0] jitter(int centre, int span);
    return COORD_BITS'(centre + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic test_reset_tolerances();
    send_item(rect_item(CMD_ADD, 1, 0, 0, 0, 5, 5));
    send_item(rect_item(CMD_ADD, 1, 0, 9, -9, 14, 0));
    send_item(rect_item(CMD_ADD, 1, 0, 10, 0, 5, 5));
    send_item(rect_item(CMD_ADD, 1, 1, -39, 30, 40, 44));
    send_item(rect_item(CMD_ADD, 2, 1, 0, 0, 5, 5));
    send_item(rect_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0));
    send_item(rect_item(CMD_FLUSH, 15, 1, -1, -1, 65535, 65535));
    settle();
  endtask

  task automatic test_extreme_tolerances();
    write_tolerances(16'hFFFF, 16'hFFFF);
    send_item(rect_item(CMD_ADD, 15, 1, -32768, -32768, 65535, 65535));
    send_item(rect_item(CMD_ADD, 15, 1, 32766, 32766, 65535, 65535));
    send_item(rect_item(CMD_ADD, 15, 0, 32767, 32767, 0, 0));
    send_item(rect_item(CMD_ADD, 0, 0, 32767, -32768, 0, 65535));
    send_item(rect_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0));
    settle();
    write_tolerances(16'd0, 16'd0);
    send_item(rect_item(CMD_ADD, 7, 1, 100, 100, 8, 8));
    send_item(rect_item(CMD_ADD, 7, 1, 100, 100, 8, 8));
    send_item(rect_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0));
    settle();
  endtask

  // zero tolerance, so every add appends and the table overflows
  task automatic test_overflow_under_hold();
    @(negedge clk_i);
    hold_left = HOLD_CYCLES;
    @(posedge clk_i);
    repeat (TABLE_ENTRIES_DEF + 4) send_item(random_rect());
    send_item(rect_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0));
    settle();
  endtask

  task automatic random_phase(int unsigned n_items);
    drc_in_t     item;
    int unsigned roll;
    int unsigned cli;
    int          span;
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      item = random_rect();
      if (roll < 8) begin
        item.command = CMD_FLUSH;
      end else if (roll >= 20) begin
        cli = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
        if ($urandom_range(99) < 15) begin
          base_x[cli] = int'($urandom_range(60000)) - 30000;
          base_y[cli] = int'($urandom_range(60000)) - 30000;
          base_w[cli] = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                                 : int'($urandom_range(2000));
          base_h[cli] = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                                 : int'($urandom_range(2000));
        end
        span = item.client_is_graphic ? int'(graphic_tol) : int'(text_tol);
        span = (span == 0) ? 3 : ((span > 300) ? 300 : span + 2);
        item.client = CLIENT_BITS'(cli);
        item.pos_x  = jitter(base_x[cli], span);
        item.pos_y  = jitter(base_y[cli], span);
        item.size_w = jitter(base_w[cli], span);
        item.size_h = jitter(base_h[cli], span);
      end
      send_item(item);
    end
    settle();
  endtask

  task automatic test_random_default();
    write_tolerances(TEXT_TOL_RESET, GRAPHIC_TOL_RESET);
    random_phase(130);
  endtask

  task automatic test_random_wide_and_zero();
    write_tolerances(16'hFFFF, 16'hFFFF);
    random_phase(60);
    write_tolerances(16'd0, 16'd0);
    random_phase(50);
    write_tolerances(16'hFFFF, 16'd0);
    random_phase(40);
    write_tolerances(16'd0, 16'hFFFF);
    random_phase(40);
  endtask

  task automatic test_random_no_idling();
    idle_on = 1'b0;
    write_tolerances(16'($urandom_range(1, 500)), 16'($urandom_range(1, 500)));
    random_phase(100);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_tolerances();
    test_extreme_tolerances();
    test_overflow_under_hold();
    test_random_default();
    test_random_wide_and_zero();
    test_random_no_idling();
    if (fail_count == 0 && expected_rects.size() == 0) begin
      $display("dirty_rect_coalescer regression: pass");
    end else begin
      $display("dirty_rect_coalescer regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/drc_pkg.sv
hw/rtl/dirty_rect_coalescer.sv
tb/sv/tb_dirty_rect_coalescer.sv
